// ----- hdl/variable_file_boolean_unit_top_assert.svh -----
// Assertion macros used by the checker file.
`ifndef VARIABLE_FILE_BOOLEAN_UNIT_TOP_ASSERT_SVH
`define VARIABLE_FILE_BOOLEAN_UNIT_TOP_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define VFBU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define VFBU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/vfbu_pkg.sv -----
`default_nettype none

package vfbu_pkg;

    localparam int REQ_W  = 2;
    localparam int OP_W   = 4;
    localparam int ADDR_W = 5;
    localparam int LOAD_W = 32;
    localparam int RES_W  = 32;

    // s_tuser layout
    localparam int REQ_LSB   = 0;
    localparam int OP_LSB    = 2;
    localparam int S_TUSER_W = 6;

    // s_tdata layout
    localparam int DEST_LSB  = 0;
    localparam int SRCA_LSB  = 5;
    localparam int SRCB_LSB  = 10;
    localparam int LOAD_LSB  = 15;
    localparam int S_TDATA_W = 48;

    localparam int M_TDATA_W = 32;

    localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ = 2'd1;
    localparam logic [REQ_W-1:0] REQ_NOT  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_BIN  = 2'd3;

    localparam logic [OP_W-1:0] OP_AND  = 4'd0;
    localparam logic [OP_W-1:0] OP_OR   = 4'd1;
    localparam logic [OP_W-1:0] OP_IMPL = 4'd2;
    localparam logic [OP_W-1:0] OP_RIMP = 4'd3;
    localparam logic [OP_W-1:0] OP_EQV  = 4'd4;
    localparam logic [OP_W-1:0] OP_XOR  = 4'd5;
    localparam logic [OP_W-1:0] OP_NIMP = 4'd6;
    localparam logic [OP_W-1:0] OP_NAND = 4'd7;
    localparam logic [OP_W-1:0] OP_NOR  = 4'd8;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [OP_W-1:0]  op_code;
    } vfbu_cmd_t;

endpackage

`default_nettype wire

// ----- hdl/vfbu_bool_alu.sv -----
`default_nettype none

module vfbu_bool_alu
    import vfbu_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  vfbu_cmd_t              cmd,
    input  logic [DATA_WIDTH-1:0]  opnd_a,
    input  logic [DATA_WIDTH-1:0]  opnd_b,
    input  logic [DATA_WIDTH-1:0]  load_val,
    output logic [DATA_WIDTH-1:0]  result,
    output logic                   wr_ok
);

    localparam logic [DATA_WIDTH-1:0] ONE = DATA_WIDTH'(1);

    // Flip bits from 0 up to the leading one; zero maps to 1.
    function automatic logic [DATA_WIDTH-1:0] wcomp(input logic [DATA_WIDTH-1:0] x);
        logic [DATA_WIDTH-1:0] m;
        m = x;
        for (int s = 1; s < DATA_WIDTH; s = s * 2) begin
            m = m | (m >> s);
        end
        return (x == '0) ? ONE : (x ^ m);
    endfunction

    logic [DATA_WIDTH-1:0] ca;
    logic [DATA_WIDTH-1:0] cb;
    logic [DATA_WIDTH-1:0] bin_res;
    logic                  bin_ok;

    assign ca = wcomp(opnd_a);
    assign cb = wcomp(opnd_b);

    always_comb begin
        bin_ok = 1'b1;
        unique case (cmd.op_code)
            OP_AND:  bin_res = opnd_a & opnd_b;
            OP_OR:   bin_res = opnd_a | opnd_b;
            OP_IMPL: bin_res = ca | opnd_b;
            OP_RIMP: bin_res = cb | opnd_a;
            OP_EQV:  bin_res = (ca & cb) | (opnd_a & opnd_b);
            OP_XOR:  bin_res = opnd_a ^ opnd_b;
            OP_NIMP: bin_res = wcomp(ca | opnd_b);
            OP_NAND: bin_res = ca | cb;
            OP_NOR:  bin_res = wcomp(opnd_a | opnd_b);
            default: begin
                bin_res = '0;
                bin_ok  = 1'b0;
            end
        endcase
    end

    always_comb begin
        unique case (cmd.req_type)
            REQ_LOAD: begin
                result = load_val;
                wr_ok  = 1'b1;
            end
            REQ_READ: begin
                result = opnd_a;
                wr_ok  = 1'b0;
            end
            REQ_NOT: begin
                result = ca;
                wr_ok  = 1'b1;
            end
            default: begin
                result = bin_res;
                wr_ok  = bin_ok;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/variable_file_boolean_unit_top.sv -----
// Register file of NUM_REGS words of DATA_WIDTH bits, all zero after reset, with a Boolean
// unit. Each input transaction loads, reads, complements (flipping bits up to the leading
// one, zero gives 1) or combines two registers, and returns exactly one output transaction
// carrying the value written or read. One transaction is accepted per cycle unless the output
// stalls: the file is read into a register as the request is accepted, and the unit and the
// write-back run as the result moves into the output register, with a bypass when a request reads the
// register the previous one writes. Indexes beyond the file read as zero and drop writes;
// undefined operation codes write nothing and return zero. s_tuser, low bits up: req_type,
// op_code. s_tdata, low bits up: dest_reg, src_a, src_b, load_value.
`default_nettype none

module variable_file_boolean_unit_top
    import vfbu_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int NUM_REGS   = 26
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // dest_reg, src_a, src_b, load_value, pad
    input  logic [S_TUSER_W-1:0]  s_tuser,   // req_type, op_code
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // result_value
);

    localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int EXT_W = ADDR_W + IDX_W;

    function automatic logic [IDX_W-1:0] to_idx(input logic [ADDR_W-1:0] a);
        logic [EXT_W-1:0] w;
        w = {{IDX_W{1'b0}}, a};
        return w[IDX_W-1:0];
    endfunction

    function automatic logic in_file(input logic [ADDR_W-1:0] a);
        logic [EXT_W-1:0] w;
        w = {{IDX_W{1'b0}}, a};
        return w < EXT_W'(NUM_REGS);
    endfunction

    // input unpack
    vfbu_cmd_t              s_cmd;
    logic [ADDR_W-1:0]      s_dest;
    logic [ADDR_W-1:0]      s_src_a;
    logic [ADDR_W-1:0]      s_src_b;
    logic [LOAD_W-1:0]      s_load;
    logic [LOAD_W+DATA_WIDTH-1:0] load_ext;
    logic [DATA_WIDTH-1:0]  s_load_dw;
    logic                   s_acc;

    assign s_cmd.req_type = s_tuser[REQ_LSB +: REQ_W];
    assign s_cmd.op_code  = s_tuser[OP_LSB +: OP_W];
    assign s_dest   = s_tdata[DEST_LSB +: ADDR_W];
    assign s_src_a  = s_tdata[SRCA_LSB +: ADDR_W];
    assign s_src_b  = s_tdata[SRCB_LSB +: ADDR_W];
    assign s_load   = s_tdata[LOAD_LSB +: LOAD_W];
    assign load_ext = {{DATA_WIDTH{1'b0}}, s_load};
    assign s_load_dw = load_ext[DATA_WIDTH-1:0];

    // stage 1
    logic                   s1_vld_reg;
    vfbu_cmd_t              s1_cmd_reg;
    logic [ADDR_W-1:0]      s1_dest_reg;
    logic                   s1_dest_ok_reg;
    logic [DATA_WIDTH-1:0]  s1_load_reg;
    logic [DATA_WIDTH-1:0]  a_mem_reg;
    logic [DATA_WIDTH-1:0]  b_mem_reg;
    logic                   a_vld_reg;
    logic                   b_vld_reg;
    logic                   a_byp_reg;
    logic                   b_byp_reg;
    logic [DATA_WIDTH-1:0]  byp_data_reg;

    logic [DATA_WIDTH-1:0]  mem [NUM_REGS];
    logic [NUM_REGS-1:0]    valid_reg;

    logic                   m_tvalid_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg;

    logic                   out_free;
    logic                   s1_fire;
    logic [DATA_WIDTH-1:0]  opnd_a;
    logic [DATA_WIDTH-1:0]  opnd_b;
    logic [DATA_WIDTH-1:0]  alu_res;
    logic                   alu_wr;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_idx;
    logic [IDX_W-1:0]       sa_idx;
    logic [IDX_W-1:0]       sb_idx;
    logic                   a_vld_next;
    logic                   b_vld_next;
    logic                   a_byp_next;
    logic                   b_byp_next;
    logic [M_TDATA_W+DATA_WIDTH-1:0] res_ext;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s1_fire  = s1_vld_reg && out_free;
    assign s_tready = !s1_vld_reg || out_free;
    assign s_acc    = s_tvalid && s_tready;

    assign opnd_a = a_byp_reg ? byp_data_reg : (a_vld_reg ? a_mem_reg : '0);
    assign opnd_b = b_byp_reg ? byp_data_reg : (b_vld_reg ? b_mem_reg : '0);

    vfbu_bool_alu #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_alu (
        .cmd      (s1_cmd_reg),
        .opnd_a   (opnd_a),
        .opnd_b   (opnd_b),
        .load_val (s1_load_reg),
        .result   (alu_res),
        .wr_ok    (alu_wr)
    );

    assign wr_en  = s1_fire && alu_wr && s1_dest_ok_reg;
    assign wr_idx = to_idx(s1_dest_reg);
    assign sa_idx = to_idx(s_src_a);
    assign sb_idx = to_idx(s_src_b);

    // Write-back of the item in stage 1 is not in the file yet when the next item reads.
    assign a_byp_next = wr_en && (s1_dest_reg == s_src_a);
    assign b_byp_next = wr_en && (s1_dest_reg == s_src_b);
    assign a_vld_next = in_file(s_src_a) ? valid_reg[sa_idx] : 1'b0;
    assign b_vld_next = in_file(s_src_b) ? valid_reg[sb_idx] : 1'b0;

    assign res_ext = {{M_TDATA_W{1'b0}}, alu_res};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= alu_res;
        end
        if (s_acc) begin
            a_mem_reg <= mem[sa_idx];
            b_mem_reg <= mem[sb_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            s1_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (s_acc) begin
                s1_vld_reg <= 1'b1;
            end else if (s1_fire) begin
                s1_vld_reg <= 1'b0;
            end
            if (s1_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_cmd_reg     <= s_cmd;
            s1_dest_reg    <= s_dest;
            s1_dest_ok_reg <= in_file(s_dest);
            s1_load_reg    <= s_load_dw;
            a_vld_reg      <= a_vld_next;
            b_vld_reg      <= b_vld_next;
            a_byp_reg      <= a_byp_next;
            b_byp_reg      <= b_byp_next;
            byp_data_reg   <= alu_res;
        end
        if (s1_fire) begin
            m_tdata_reg <= res_ext[M_TDATA_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ----- hdl/vfbu_checker.sv -----
`default_nettype none

`include "variable_file_boolean_unit_top_assert.svh"

module vfbu_checker
    import vfbu_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int NUM_REGS   = 26
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic [S_TUSER_W-1:0]  s_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [M_TDATA_W-1:0]  m_tdata
);

    logic s_acc;
    logic is_load;
    logic is_read;
    logic dest_in_file;

    assign s_acc        = s_tvalid && s_tready;
    assign is_load      = s_tuser[REQ_LSB +: REQ_W] == REQ_LOAD;
    assign is_read      = s_tuser[REQ_LSB +: REQ_W] == REQ_READ;
    assign dest_in_file = 32'(s_tdata[DEST_LSB +: ADDR_W]) < NUM_REGS;

    // input never stalls while the output drains
    `VFBU_ASSERT_IMP(a_ready_when_drain, m_tready, s_tready, "input stalled while output drains")

    // an accepted transaction passes stage 1 into the output register when m_tready is high while it waits there
    `VFBU_ASSERT_NXT(a_two_cycle, s_acc ##1 m_tready, m_tvalid, "result missing after two cycles")

    // nothing appears on the output without an accepted input passed through stage 1
    `VFBU_ASSERT_IMP(a_no_invent, $rose(m_tvalid), $past(s_acc, 2), "result without request")

    `VFBU_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

    // load then immediate read of the same register goes through the bypass
    `VFBU_ASSERT_NXT(a_load_read_bypass, (s_acc && is_load && dest_in_file && (DATA_WIDTH >= RES_W)) ##1 (s_acc && is_read && (s_tdata[SRCA_LSB +: ADDR_W] == $past(s_tdata[DEST_LSB +: ADDR_W])) && m_tready) ##1 m_tready, m_tdata == $past(s_tdata[LOAD_LSB +: LOAD_W], 3), "read after load returned stale value")

endmodule

bind variable_file_boolean_unit_top vfbu_checker #(
    .DATA_WIDTH(DATA_WIDTH),
    .NUM_REGS  (NUM_REGS)
) u_vfbu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
